// ===== sv/bffa_pkg.sv =====
package bffa_pkg;

    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = CNT_W;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INODE_COUNT = 1'b0,
        REG_BLOCK_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        MAP_INODE = 1'b0,
        MAP_BLOCK = 1'b1
    } t_map;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PUSH
    } t_state;

endpackage

// ===== sv/bffa_ram.sv =====
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bitmap_first_free_allocator.sv =====
// Two first-fit allocation bitmaps (inode map and data block map) held in one
// 32-bit-wide synchronous RAM, one half per map. An allocate request scans its map
// one 32-bit word per cycle from word 0 and claims the lowest clear bit below the
// map's count register, reading one word for a zero count, otherwise at most
// ceil(count / 32) words (32 for a full 1024-entry map); the next request is
// accepted only once the current one is done. A free request reads and rewrites
// one word. The RAM's single read port, one word per cycle, sets the scan
// rate. After reset the block sweeps the RAM to zero, one word a cycle (all 64
// words with MAP_ENTRIES = 1024, twice the power-of-two word count in general), and
// stalls its input until the sweep ends; count registers may be written at any
// time the block is idle. A finished result waits in an output register while
// the next item is accepted.
module bitmap_first_free_allocator #(
    parameter int MAP_ENTRIES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_in_cmd,
    input  logic                             i_in_map_select,
    input  logic [bffa_pkg::IDX_W-1:0]       i_in_entry_index,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_out_status,
    output logic [bffa_pkg::IDX_W-1:0]       o_out_granted_index,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bffa_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int WORD_W = bffa_pkg::WORD_W;
    localparam int BIT_W  = bffa_pkg::BIT_W;
    localparam int IDX_W  = bffa_pkg::IDX_W;
    localparam int CNT_W  = bffa_pkg::CNT_W;
    localparam int WORDS  = (MAP_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW     = WA_W + 1;
    localparam int DEPTH  = 2 ** AW;
    localparam int LIM_W  = ($clog2(MAP_ENTRIES + 1) > CNT_W) ? $clog2(MAP_ENTRIES + 1) : CNT_W;

    bffa_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;
    logic [CNT_W-1:0]  r_inode_count, n_inode_count;
    logic [CNT_W-1:0]  r_block_count, n_block_count;

    bffa_pkg::t_cmd    r_cmd, n_cmd;
    logic              r_sel, n_sel;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WA_W-1:0]   r_word, n_word;
    bffa_pkg::t_status r_res_status, n_res_status;
    logic [IDX_W-1:0]  r_res_granted, n_res_granted;
    bffa_pkg::t_status r_out_status, n_out_status;
    logic [IDX_W-1:0]  r_out_granted, n_out_granted;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [CNT_W-1:0]  cnt_sel;
    logic [LIM_W-1:0]  cnt_ext;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  base;
    logic [LIM_W-1:0]  rem;
    logic              last_word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic              found;
    logic [BIT_W-1:0]  pos;
    logic              in_range;
    logic              in_acc;
    logic [WA_W-1:0]   in_word;

    bffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // map limit and word mask
    always_comb begin
        cnt_sel   = (r_sel == bffa_pkg::MAP_BLOCK) ? r_block_count : r_inode_count;
        cnt_ext   = LIM_W'(cnt_sel);
        limit     = (cnt_ext > LIM_W'(MAP_ENTRIES)) ? LIM_W'(MAP_ENTRIES) : cnt_ext;
        base      = LIM_W'({r_word, {BIT_W{1'b0}}});
        rem       = limit - base;
        last_word = (rem <= LIM_W'(WORD_W));
        if (rem >= LIM_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
        end
        free_bits = ~ram_rdata & mask;
        found     = |free_bits;
        pos       = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                pos = BIT_W'(i);
            end
        end
        in_range  = (LIM_W'(r_idx) < limit);
    end

    assign o_in_stall  = (r_state != bffa_pkg::S_IDLE);
    assign in_acc      = i_in_valid && (r_state == bffa_pkg::S_IDLE);
    assign in_word     = (bffa_pkg::t_cmd'(i_in_cmd) == bffa_pkg::CMD_FREE)
                         ? WA_W'(i_in_entry_index >> BIT_W) : '0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_inode_count = r_inode_count;
        n_block_count = r_block_count;
        n_cmd         = r_cmd;
        n_sel         = r_sel;
        n_idx         = r_idx;
        n_word        = r_word;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        ram_we        = 1'b0;
        ram_waddr     = {r_sel, r_word};
        ram_wdata     = ram_rdata;
        ram_raddr     = {r_sel, r_word};

        if (i_cfg_valid) begin
            unique case (bffa_pkg::t_cfg_reg'(i_cfg_index))
                bffa_pkg::REG_INODE_COUNT: n_inode_count = i_cfg_data;
                bffa_pkg::REG_BLOCK_COUNT: n_block_count = i_cfg_data;
            endcase
        end

        unique case (r_state)
            bffa_pkg::S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = bffa_pkg::S_IDLE;
                end
            end
            bffa_pkg::S_IDLE: begin
                ram_raddr = {i_in_map_select, in_word};
                if (in_acc) begin
                    n_cmd   = bffa_pkg::t_cmd'(i_in_cmd);
                    n_sel   = i_in_map_select;
                    n_idx   = i_in_entry_index;
                    n_word  = in_word;
                    n_state = bffa_pkg::S_CHECK;
                end
            end
            bffa_pkg::S_CHECK: begin
                n_res_granted = '0;
                if (r_cmd == bffa_pkg::CMD_FREE) begin
                    n_state = bffa_pkg::S_PUSH;
                    if (in_range) begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata & ~(WORD_W'(1) << r_idx[BIT_W-1:0]);
                        n_res_status = bffa_pkg::ST_OK;
                    end else begin
                        n_res_status = bffa_pkg::ST_RANGE;
                    end
                end else begin
                    priority if (found) begin
                        ram_we        = 1'b1;
                        ram_wdata     = ram_rdata | (WORD_W'(1) << pos);
                        n_res_status  = bffa_pkg::ST_OK;
                        n_res_granted = IDX_W'({r_word, pos});
                        n_state       = bffa_pkg::S_PUSH;
                    end else if (last_word) begin
                        n_res_status  = bffa_pkg::ST_FULL;
                        n_state       = bffa_pkg::S_PUSH;
                    end else begin
                        n_word    = r_word + WA_W'(1);
                        ram_raddr = {r_sel, n_word};
                    end
                end
            end
            bffa_pkg::S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_state       = bffa_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bffa_pkg::S_CLEAR;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_inode_count <= bffa_pkg::COUNT_RESET;
            r_block_count <= bffa_pkg::COUNT_RESET;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_out_valid   <= n_out_valid;
            r_inode_count <= n_inode_count;
            r_block_count <= n_block_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_sel         <= n_sel;
        r_idx         <= n_idx;
        r_word        <= n_word;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_out_status;
    assign o_out_granted_index = r_out_granted;

endmodule

// ===== sv/bffa_checker.sv =====
module bffa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [1:0]                 o_out_status,
    input logic [bffa_pkg::IDX_W-1:0] o_out_granted_index
);

    // no result code beyond range error
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_status == bffa_pkg::ST_OK ||
                         o_out_status == bffa_pkg::ST_FULL ||
                         o_out_status == bffa_pkg::ST_RANGE))
        else $error("bad status code");

    // failures never carry an index
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status != bffa_pkg::ST_OK) |-> (o_out_granted_index == '0))
        else $error("failed item carries an index");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted back to back");

    // clearing sweep holds off items after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("item accepted during clearing sweep");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_status) && $stable(o_out_granted_index)))
        else $error("stalled result changed");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_SIZE      = 1024;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int IDX_W         = bffa_pkg::IDX_W;
    localparam int CNT_W         = bffa_pkg::CNT_W;
    localparam int CFG_IDX_W     = bffa_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W     = bffa_pkg::CFG_DAT_W;

    typedef struct packed {
        bffa_pkg::t_status status;
        logic [IDX_W-1:0]  granted;
    } t_alloc_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_in_cmd = 1'b0;
    logic                 i_in_map_select = 1'b0;
    logic [IDX_W-1:0]     i_in_entry_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_out_status;
    logic [IDX_W-1:0]     o_out_granted_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    logic [MAP_SIZE-1:0]  inode_taken;
    logic [MAP_SIZE-1:0]  block_taken;
    logic [CNT_W-1:0]     inode_count;
    logic [CNT_W-1:0]     block_count;
    t_alloc_result        pending_results[$];
    int                   error_count = 0;
    int                   burst_left = 0;
    int                   quiet_cycles = 0;
    int                   stall_run = 0;
    int                   stall_mode = 0;
    int                   cycle_cnt = 0;

    bitmap_first_free_allocator #(
        .MAP_ENTRIES(MAP_SIZE)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_cmd            (i_in_cmd),
        .i_in_map_select     (i_in_map_select),
        .i_in_entry_index    (i_in_entry_index),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_status        (o_out_status),
        .o_out_granted_index (o_out_granted_index),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int usable_entries(input bffa_pkg::t_map m);
        int cnt;
        cnt = (m == bffa_pkg::MAP_BLOCK) ? int'(block_count) : int'(inode_count);
        return (cnt > MAP_SIZE) ? MAP_SIZE : cnt;
    endfunction

    function automatic t_alloc_result allocate_or_free(input bffa_pkg::t_cmd c,
                                                       input bffa_pkg::t_map m,
                                                       input logic [IDX_W-1:0] idx);
        t_alloc_result res;
        logic [MAP_SIZE-1:0] bits;
        int lim;
        lim = usable_entries(m);
        bits = (m == bffa_pkg::MAP_BLOCK) ? block_taken : inode_taken;
        res.status = bffa_pkg::ST_FULL;
        res.granted = '0;
        if (c == bffa_pkg::CMD_ALLOC) begin
            for (int i = 0; i < lim; i++) begin
                if (!bits[i]) begin
                    bits[i] = 1'b1;
                    res.status = bffa_pkg::ST_OK;
                    res.granted = IDX_W'(i);
                    break;
                end
            end
        end else if (int'(idx) < lim) begin
            bits[idx] = 1'b0;
            res.status = bffa_pkg::ST_OK;
        end else begin
            res.status = bffa_pkg::ST_RANGE;
        end
        if (m == bffa_pkg::MAP_BLOCK)
            block_taken = bits;
        else
            inode_taken = bits;
        return res;
    endfunction

    task automatic send_request(input bffa_pkg::t_cmd c, input bffa_pkg::t_map m,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_cmd <= c;
        i_in_map_select <= m;
        i_in_entry_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(allocate_or_free(c, m, idx));
        burst_left--;
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        release_input();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input bffa_pkg::t_cfg_reg r, input logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (r == bffa_pkg::REG_INODE_COUNT)
            inode_count = value;
        else
            block_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        unique case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd31;
            3: return 11'd32;
            4: return 11'd33;
            5: return 11'd1024;
            6: return 11'd2047;
            7: return 11'd1025;
            8: return CNT_W'($urandom_range(0, 2047));
            default: return CNT_W'($urandom_range(2, 64));
        endcase
    endfunction

    task automatic test_basic_alloc_free();
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'h3ff);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_BLOCK, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'h3ff);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_BLOCK, 10'h2aa);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_BLOCK, 10'h155);
        wait_idle();
    endtask

    task automatic test_zero_count();
        write_count(bffa_pkg::REG_INODE_COUNT, 11'd0);
        write_count(bffa_pkg::REG_BLOCK_COUNT, 11'd0);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_BLOCK, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_BLOCK, 10'h3ff);
        wait_idle();
    endtask

    task automatic test_saturated_count();
        write_count(bffa_pkg::REG_INODE_COUNT, 11'd2047);
        write_count(bffa_pkg::REG_BLOCK_COUNT, 11'd1025);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'h3ff);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_BLOCK, 10'd0);
        wait_idle();
    endtask

    task automatic test_lowered_count();
        write_count(bffa_pkg::REG_INODE_COUNT, 11'd3);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd3);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd1);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        wait_idle();
        write_count(bffa_pkg::REG_INODE_COUNT, 11'd1);
        send_request(bffa_pkg::CMD_FREE, bffa_pkg::MAP_INODE, 10'd1);
        send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::MAP_INODE, 10'd0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int n_items;
        int alloc_pct;
        int inode_pct;
        int lim;
        bffa_pkg::t_cmd c;
        bffa_pkg::t_map m;
        logic [IDX_W-1:0] idx;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // first phase fills the inode map deep with mostly inode allocations
            if (ph == 0) begin
                write_count(bffa_pkg::REG_INODE_COUNT, 11'd1024);
                write_count(bffa_pkg::REG_BLOCK_COUNT, 11'd1024);
                n_items = 700;
                alloc_pct = 90;
                inode_pct = 85;
            end else begin
                write_count(bffa_pkg::REG_INODE_COUNT, pick_count());
                write_count(bffa_pkg::REG_BLOCK_COUNT, pick_count());
                n_items = 110;
                alloc_pct = $urandom_range(30, 70);
                inode_pct = 50;
            end
            for (int k = 0; k < n_items; k++) begin
                c = ($urandom_range(0, 99) < alloc_pct) ? bffa_pkg::CMD_ALLOC
                                                        : bffa_pkg::CMD_FREE;
                m = ($urandom_range(0, 99) < inode_pct) ? bffa_pkg::MAP_INODE
                                                        : bffa_pkg::MAP_BLOCK;
                lim = usable_entries(m);
                if ($urandom_range(0, 9) < 7)
                    idx = IDX_W'($urandom_range(0, (lim + 1 > 1023) ? 1023 : lim + 1));
                else
                    idx = IDX_W'($urandom);
                send_request(c, m, idx);
            end
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run <= $urandom_range(30, 150);
        end else begin
            stall_run <= stall_run - 1;
        end
        unique case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ((cycle_cnt % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item status %0d granted %0d", $time,
                         o_out_status, o_out_granted_index);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, o_out_status);
                    error_count++;
                end
                if (o_out_granted_index !== exp_res.granted) begin
                    $display("%0t: granted_index expected %0d actual %0d", $time,
                             exp_res.granted, o_out_granted_index);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        inode_taken = '0;
        block_taken = '0;
        inode_count = bffa_pkg::COUNT_RESET;
        block_count = bffa_pkg::COUNT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_alloc_free();
        test_zero_count();
        test_saturated_count();
        test_lowered_count();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
